// ===== rtl/core/acbc_pkg.sv =====
// Package: shared types, constants and GF helpers for the AES-256 CBC decryptor.
`timescale 1ns / 1ps
package acbc_pkg;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        final_block;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic [4:0]  byte_count;
    logic        end_of_message;
    logic [1:0]  status;
  } out_beat_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_PAD_VAL  = 2'd2;
  localparam logic [1:0] ST_PAD_MISM = 2'd3;

  localparam logic [1:0] CFG_KEY0 = 2'd0;
  localparam logic [1:0] CFG_KEY1 = 2'd1;
  localparam logic [1:0] CFG_KEY2 = 2'd2;
  localparam logic [1:0] CFG_KEY3 = 2'd3;

  localparam int RK_DEPTH = 30;
  localparam int RK_AW    = 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXPAND,
    S_LOAD,
    S_ROUND,
    S_FINISH,
    S_OUT
  } state_t;

  // Key-expansion step request from the top to the expander.
  typedef struct packed {
    logic             start;
    logic [RK_AW-1:0] step;
  } kx_ctl_t;

  localparam logic [7:0] FBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] IBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] v);
    xt = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] v, input logic [3:0] f);
    logic [7:0] a, b, c;
    a = xt(v);
    b = xt(a);
    c = xt(b);
    gmul = (f[0] ? v : 8'h00) ^ (f[1] ? a : 8'h00) ^ (f[2] ? b : 8'h00) ^ (f[3] ? c : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    sbox_word = {FBOX[w[31:24]], FBOX[w[23:16]], FBOX[w[15:8]], FBOX[w[7:0]]};
  endfunction

endpackage

// ===== rtl/core/acbc_keyexp.sv =====
// Key expander: produces one 64-bit round key word per step from the key registers.
`timescale 1ns / 1ps
module acbc_keyexp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  acbc_pkg::kx_ctl_t         ctl,
  input  logic [255:0]              key,
  output logic [63:0]               word
);

  // Sliding window of the last eight key words (w[i-8..i-1]), word 0 oldest.
  logic [255:0] win_r, win_nxt;
  logic [7:0]   rc_r, rc_nxt;
  logic [31:0]  t0, t1, n0, n1;
  logic [31:0]  last;

  always_comb begin
    last = win_r[31:0];
    // Steps 0..3 pass the key through; later steps make two words.
    // Word pair k (k>=4) starts at 32-bit index 2k: rot/sub when 2k%8==0, sub when 2k%8==4.
    unique case (ctl.step[1:0])
      2'd0: t0 = acbc_pkg::sbox_word({last[23:0], last[31:24]}) ^ {rc_r, 24'h0};
      2'd2: t0 = acbc_pkg::sbox_word(last);
      default: t0 = last;
    endcase
    n0 = win_r[255:224] ^ t0;
    t1 = n0;
    n1 = win_r[223:192] ^ t1;
  end

  always_comb begin
    win_nxt = win_r;
    rc_nxt  = rc_r;
    if (ctl.start) begin
      win_nxt = key;
      rc_nxt  = 8'h01;
      word    = key[255:192];
    end else if (ctl.step < 5'd4) begin
      word = win_r[255 - 64*ctl.step[1:0] -: 64];
    end else begin
      word    = {n0, n1};
      win_nxt = {win_r[191:0], n0, n1};
      if (ctl.step[1:0] == 2'd0) begin
        rc_nxt = acbc_pkg::xt(rc_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= 8'h01;
    end else begin
      rc_r <= rc_nxt;
    end
    win_r <= win_nxt;
  end

endmodule

// ===== rtl/core/acbc_round.sv =====
// One inverse AES round: shift, substitute, add key, optional inverse mix.
`timescale 1ns / 1ps
module acbc_round (
  input  logic [127:0] st,
  input  logic [127:0] rk,
  input  logic         mix,
  output logic [127:0] res
);

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = st[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[((c + r) % 4) * 4 + r] = acbc_pkg::IBOX[s[c*4 + r]] ^ 8'h00;
      end
    end
    for (int i = 0; i < 16; i++) begin
      t[i] = t[i] ^ rk[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      m[c*4]   = acbc_pkg::gmul(t[c*4], 4'he) ^ acbc_pkg::gmul(t[c*4+1], 4'hb)
               ^ acbc_pkg::gmul(t[c*4+2], 4'hd) ^ acbc_pkg::gmul(t[c*4+3], 4'h9);
      m[c*4+1] = acbc_pkg::gmul(t[c*4], 4'h9) ^ acbc_pkg::gmul(t[c*4+1], 4'he)
               ^ acbc_pkg::gmul(t[c*4+2], 4'hb) ^ acbc_pkg::gmul(t[c*4+3], 4'hd);
      m[c*4+2] = acbc_pkg::gmul(t[c*4], 4'hd) ^ acbc_pkg::gmul(t[c*4+1], 4'h9)
               ^ acbc_pkg::gmul(t[c*4+2], 4'he) ^ acbc_pkg::gmul(t[c*4+3], 4'hb);
      m[c*4+3] = acbc_pkg::gmul(t[c*4], 4'hb) ^ acbc_pkg::gmul(t[c*4+1], 4'hd)
               ^ acbc_pkg::gmul(t[c*4+2], 4'h9) ^ acbc_pkg::gmul(t[c*4+3], 4'he);
    end
    for (int i = 0; i < 16; i++) begin
      res[127 - 8*i -: 8] = mix ? m[i] : t[i];
    end
  end

endmodule

// ===== rtl/core/aes256_cbc_decrypt_pkcs7.sv =====
// Top level: AES-256 CBC decryptor with PKCS7 pad check and round key memory.
//
// Usage: write the 256-bit key through cfg_we/cfg_index/cfg_wdata while idle.
// Send ciphertext one 128-bit block per in_ beat; final_block marks the last.
// The first block of each message is decrypted into the chaining value and
// gives no out_ beat; each later block gives one out_ beat. A message of one
// block gives a single beat with status "too short".
// The round key memory holds two 64-bit words per round and is read
// one word per cycle: a load state, a round state that walks the fifteen
// round keys and a finish state that hands the result on. When a key has
// changed, the first block of a message first fills the memory, one word
// per cycle from the key expander.
// One block is in work at a time. A finished result sits in the output
// register; the next block is accepted and processed meanwhile and waits
// only if that register is still full when its result is ready.
// Reset clears the control state: keys must be re-expanded, the next block
// starts a message. The chaining value is reset to zero.
`timescale 1ns / 1ps
module aes256_cbc_decrypt_pkcs7 (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  acbc_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output acbc_pkg::out_beat_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_wdata
);

  acbc_pkg::state_t state_r, state_nxt;

  logic [63:0]  rk_mem [acbc_pkg::RK_DEPTH];
  logic [63:0]  rk_q;
  logic [4:0]   rd_addr;
  logic         mem_we;
  logic [4:0]   wr_addr;
  logic [63:0]  wr_data;

  logic [255:0] key_r;
  logic         keys_ready_r, keys_ready_nxt;
  logic         awaiting_iv_r, awaiting_iv_nxt;
  logic [127:0] chain_r, chain_nxt;
  logic [127:0] blk_r;
  logic         fin_r;
  logic [127:0] st_r, st_nxt;
  logic [63:0]  rk_hi_r;
  logic [4:0]   cnt_r, cnt_nxt;
  logic         out_valid_r;
  acbc_pkg::out_beat_t out_r, res;

  acbc_pkg::kx_ctl_t kx_ctl;
  logic [63:0]  kx_word;
  logic [127:0] rnd_res;
  logic [3:0]   rnd_idx;

  logic         accept;
  logic         emit;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == acbc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  acbc_keyexp u_keyexp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (kx_ctl),
    .key   (key_r),
    .word  (kx_word)
  );

  // Round counter: cnt counts words; round index = cnt[4:1].
  assign rnd_idx = cnt_r[4:1];

  acbc_round u_round (
    .st  (st_r),
    .rk  ({rk_hi_r, rk_q}),
    .mix (rnd_idx != 4'd0),
    .res (rnd_res)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rk_mem[wr_addr] <= wr_data;
    end
    rk_q <= rk_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      acbc_pkg::S_IDLE: begin
        if (accept) begin
          if (awaiting_iv_r && in_data.final_block) begin
            state_nxt = acbc_pkg::S_OUT;
          end else if (awaiting_iv_r && !keys_ready_r) begin
            state_nxt = acbc_pkg::S_EXPAND;
          end else begin
            state_nxt = acbc_pkg::S_LOAD;
          end
        end
      end
      acbc_pkg::S_EXPAND: begin
        if (cnt_r == 5'd29) begin
          state_nxt = acbc_pkg::S_LOAD;
        end
      end
      acbc_pkg::S_LOAD:   state_nxt = acbc_pkg::S_ROUND;
      acbc_pkg::S_ROUND: begin
        if (cnt_r == 5'd1) begin
          state_nxt = acbc_pkg::S_FINISH;
        end
      end
      acbc_pkg::S_FINISH: begin
        if (awaiting_iv_r) begin
          state_nxt = acbc_pkg::S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          state_nxt = acbc_pkg::S_IDLE;
        end
      end
      acbc_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = acbc_pkg::S_IDLE;
        end
      end
      default: state_nxt = acbc_pkg::S_IDLE;
    endcase
  end

  // Result assembly and pad check.
  always_comb begin
    logic [127:0] p;
    logic [7:0]   pad;
    logic [1:0]   stat;
    p    = st_r ^ chain_r;
    pad  = p[7:0];
    stat = acbc_pkg::ST_OK;
    if (pad == 8'd0 || pad > 8'd16) begin
      stat = acbc_pkg::ST_PAD_VAL;
    end else begin
      for (int i = 0; i < 16; i++) begin
        if (i >= 16 - pad && p[127 - 8*i -: 8] != pad) begin
          stat = acbc_pkg::ST_PAD_MISM;
        end
      end
    end
    res.end_of_message = fin_r;
    res.status         = acbc_pkg::ST_OK;
    res.byte_count     = 5'd16;
    res.plain_high     = p[127:64];
    res.plain_low      = p[63:0];
    if (fin_r) begin
      res.status = stat;
      if (stat != acbc_pkg::ST_OK) begin
        res.byte_count = 5'd0;
        res.plain_high = '0;
        res.plain_low  = '0;
      end else begin
        res.byte_count = 5'd16 - pad[4:0];
      end
    end
  end

  always_comb begin
    cnt_nxt         = cnt_r;
    st_nxt          = st_r;
    keys_ready_nxt  = keys_ready_r;
    awaiting_iv_nxt = awaiting_iv_r;
    chain_nxt       = chain_r;
    kx_ctl.start    = 1'b0;
    kx_ctl.step     = cnt_r;
    mem_we          = 1'b0;
    wr_addr         = cnt_r;
    wr_data         = kx_word;
    rd_addr         = cnt_r;
    emit            = 1'b0;
    unique case (state_r)
      acbc_pkg::S_IDLE: begin
        cnt_nxt = 5'd29;
        rd_addr = 5'd28;
        if (accept) begin
          st_nxt = {in_data.block_high, in_data.block_low};
        end
        if (accept && awaiting_iv_r && !keys_ready_r && !in_data.final_block) begin
          cnt_nxt      = 5'd0;
          kx_ctl.start = 1'b1;
        end
      end
      acbc_pkg::S_EXPAND: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        rd_addr = 5'd28;
        if (cnt_r == 5'd29) begin
          keys_ready_nxt = 1'b1;
          cnt_nxt        = 5'd29;
        end
      end
      acbc_pkg::S_LOAD: begin
        // rk_q holds word 28; fetch word 29, then add round 14 key next cycle.
        rd_addr = 5'd29;
        cnt_nxt = 5'd29;
      end
      acbc_pkg::S_ROUND: begin
        // Odd count: rk_q is the low word of round cnt/2; even: high word of round cnt/2 - 1.
        if (cnt_r[0]) begin
          rd_addr = (cnt_r == 5'd1) ? 5'd28 : cnt_r - 5'd3;
        end else begin
          rd_addr = cnt_r - 5'd1;
        end
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd29) begin
          st_nxt = st_r ^ {rk_hi_r, rk_q};
          rd_addr = 5'd26;
        end else if (cnt_r[0]) begin
          st_nxt = rnd_res;
        end
      end
      acbc_pkg::S_FINISH: begin
        if (awaiting_iv_r) begin
          chain_nxt       = st_r;
          awaiting_iv_nxt = 1'b0;
        end else if (!out_valid_r || out_ready) begin
          emit      = 1'b1;
          chain_nxt = blk_r;
          if (fin_r) begin
            awaiting_iv_nxt = 1'b1;
          end
        end
      end
      acbc_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          emit = 1'b1;
        end
      end
      default: ;
    endcase
    if (cfg_we) begin
      keys_ready_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= acbc_pkg::S_IDLE;
      keys_ready_r  <= 1'b0;
      awaiting_iv_r <= 1'b1;
      chain_r       <= '0;
      out_valid_r   <= 1'b0;
      key_r         <= '0;
      cnt_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      keys_ready_r  <= keys_ready_nxt;
      awaiting_iv_r <= awaiting_iv_nxt;
      chain_r       <= chain_nxt;
      cnt_r         <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          acbc_pkg::CFG_KEY0: key_r[255:192] <= cfg_wdata;
          acbc_pkg::CFG_KEY1: key_r[191:128] <= cfg_wdata;
          acbc_pkg::CFG_KEY2: key_r[127:64]  <= cfg_wdata;
          acbc_pkg::CFG_KEY3: key_r[63:0]    <= cfg_wdata;
        endcase
      end
    end
    rk_hi_r <= rk_q;
    st_r    <= st_nxt;
    if (accept) begin
      blk_r <= {in_data.block_high, in_data.block_low};
      fin_r <= in_data.final_block;
    end
    if (emit) begin
      if (state_r == acbc_pkg::S_OUT) begin
        out_r <= '{plain_high: '0, plain_low: '0, byte_count: 5'd0,
                   end_of_message: 1'b1, status: acbc_pkg::ST_SHORT};
      end else begin
        out_r <= res;
      end
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == acbc_pkg::S_IDLE))
    else $error("in_ready outside idle");
  a_keys_after_expand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == acbc_pkg::S_LOAD && !$past(cfg_we)) |-> keys_ready_r)
    else $error("cipher start without expanded keys");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

endmodule

// ===== dv/acbc_checker.sv =====
// Checker: AES-256 CBC decrypt predictor and result scoreboard.
`timescale 1ns / 1ps
module acbc_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  acbc_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  acbc_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_wdata,
  output int                  fail_count,
  output int                  pending,
  output int                  plain_seen,
  output int                  status_seen [4]
);

  logic [7:0] sbox_f [256];
  logic [7:0] sbox_i [256];
  logic [63:0] key_reg [4];
  logic [63:0] rk_words [30];
  bit keys_valid;
  bit need_iv;
  logic [127:0] chain;
  acbc_pkg::out_beat_t plain_q [$];

  function automatic logic [7:0] dbl8(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_scale(logic [7:0] v, int f);
    logic [7:0] acc;
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      if (f[k]) acc ^= v;
      v = dbl8(v);
    end
    return acc;
  endfunction

  task automatic build_round_keys();
    logic [7:0] w [240];
    logic [7:0] t [4];
    logic [7:0] tmp, rc;
    rc = 8'h01;
    for (int i = 0; i < 32; i++) w[i] = key_reg[i / 8][63 - 8 * (i % 8) -: 8];
    for (int i = 32; i < 240; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = w[i - 4 + j];
      if (i % 32 == 0) begin
        tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
        for (int j = 0; j < 4; j++) t[j] = sbox_f[t[j]];
        t[0] ^= rc;
        rc = dbl8(rc);
      end else if (i % 32 == 16) begin
        for (int j = 0; j < 4; j++) t[j] = sbox_f[t[j]];
      end
      for (int j = 0; j < 4; j++) w[i + j] = w[i - 32 + j] ^ t[j];
    end
    for (int i = 0; i < 30; i++)
      for (int j = 0; j < 8; j++) rk_words[i][63 - 8 * j -: 8] = w[i * 8 + j];
    keys_valid = 1;
  endtask

  function automatic logic [127:0] inv_cipher_blk(logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [127:0] rk;
    logic [7:0] a, b, c, d;
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
    for (int r = 14; r >= 0; r--) begin
      if (r < 14) begin
        t = s;
        for (int cc = 0; cc < 4; cc++)
          for (int rr = 0; rr < 4; rr++) s[((cc + rr) % 4) * 4 + rr] = sbox_i[t[cc * 4 + rr]];
      end
      rk = {rk_words[2 * r], rk_words[2 * r + 1]};
      for (int i = 0; i < 16; i++) s[i] ^= rk[127 - 8 * i -: 8];
      if (r > 0 && r < 14) begin
        for (int cc = 0; cc < 4; cc++) begin
          a = s[cc * 4]; b = s[cc * 4 + 1]; c = s[cc * 4 + 2]; d = s[cc * 4 + 3];
          s[cc * 4]     = gf_scale(a, 14) ^ gf_scale(b, 11) ^ gf_scale(c, 13) ^ gf_scale(d, 9);
          s[cc * 4 + 1] = gf_scale(a, 9) ^ gf_scale(b, 14) ^ gf_scale(c, 11) ^ gf_scale(d, 13);
          s[cc * 4 + 2] = gf_scale(a, 13) ^ gf_scale(b, 9) ^ gf_scale(c, 14) ^ gf_scale(d, 11);
          s[cc * 4 + 3] = gf_scale(a, 11) ^ gf_scale(b, 13) ^ gf_scale(c, 9) ^ gf_scale(d, 14);
        end
      end
    end
    for (int i = 0; i < 16; i++) blk[127 - 8 * i -: 8] = s[i];
    return blk;
  endfunction

  task automatic predict_plain(acbc_pkg::in_beat_t beat);
    acbc_pkg::out_beat_t o;
    logic [127:0] p;
    logic [7:0] pad;
    o = '0;
    if (need_iv) begin
      if (beat.final_block) begin
        o.end_of_message = 1;
        o.status = acbc_pkg::ST_SHORT;
        plain_q.push_back(o);
        return;
      end
      if (!keys_valid) build_round_keys();
      chain = inv_cipher_blk({beat.block_high, beat.block_low});
      need_iv = 0;
      return;
    end
    p = inv_cipher_blk({beat.block_high, beat.block_low}) ^ chain;
    chain = {beat.block_high, beat.block_low};
    o.byte_count = 16;
    o.status = acbc_pkg::ST_OK;
    if (beat.final_block) begin
      pad = p[7:0];
      if (pad == 0 || pad > 16) o.status = acbc_pkg::ST_PAD_VAL;
      else
        for (int i = 16 - pad; i < 16; i++)
          if (p[127 - 8 * i -: 8] != pad) o.status = acbc_pkg::ST_PAD_MISM;
      if (o.status != acbc_pkg::ST_OK) begin
        p = '0;
        o.byte_count = 0;
      end else o.byte_count = 16 - pad;
      o.end_of_message = 1;
      need_iv = 1;
    end
    {o.plain_high, o.plain_low} = p;
    plain_q.push_back(o);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      sbox_f[i] = acbc_pkg::FBOX[i];
      sbox_i[i] = acbc_pkg::IBOX[i];
    end
    fail_count = 0;
    pending = 0;
    plain_seen = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    for (int i = 0; i < 4; i++) key_reg[i] = 0;
    keys_valid = 0;
    need_iv = 1;
    chain = 0;
  end

  always @(posedge clk) begin
    acbc_pkg::out_beat_t w;
    if (!rst_n) begin
      keys_valid = 0;
      need_iv = 1;
      chain = 0;
      plain_q.delete();
      for (int i = 0; i < 4; i++) key_reg[i] = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (plain_q.size() == 0) begin
          report_mismatch("unexpected beat", out_data.plain_high, 0);
        end else begin
          w = plain_q.pop_front();
          plain_seen++;
          status_seen[w.status]++;
          if (out_data.plain_high !== w.plain_high)
            report_mismatch("plain_high", out_data.plain_high, w.plain_high);
          if (out_data.plain_low !== w.plain_low)
            report_mismatch("plain_low", out_data.plain_low, w.plain_low);
          if (out_data.byte_count !== w.byte_count)
            report_mismatch("byte_count", out_data.byte_count, w.byte_count);
          if (out_data.end_of_message !== w.end_of_message)
            report_mismatch("end_of_message", out_data.end_of_message, w.end_of_message);
          if (out_data.status !== w.status)
            report_mismatch("status", out_data.status, w.status);
        end
      end
      if (in_valid && in_ready) predict_plain(in_data);
      if (cfg_we) begin
        key_reg[cfg_index] = cfg_wdata;
        keys_valid = 0;
      end
    end
    pending = plain_q.size();
  end
endmodule

// ===== dv/tb.sv =====
// Testbench top: stimulus, key setup and verdict for the AES-256 CBC decryptor.
`timescale 1ns / 1ps
module tb;

  localparam int STALL_LIMIT = 4000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  acbc_pkg::in_beat_t in_data;
  acbc_pkg::out_beat_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [63:0] cfg_wdata;
  int fail_count, pending, plain_seen;
  int status_seen [4];
  int send_idle, recv_stall, quiet_cycles, beats_sent;

  aes256_cbc_decrypt_pkcs7 i_dut (.*);

  acbc_checker i_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_beat(logic [63:0] hi, logic [63:0] lo, logic fin);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_data <= '{block_high: hi, block_low: lo, final_block: fin};
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
    logic [63:0] k [4];
    k = '{k0, k1, k2, k3};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= i[1:0];
      cfg_wdata <= k[i];
      @(negedge clk);
    end
    cfg_we <= 0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_message(int blocks);
    for (int b = 0; b < blocks; b++) send_beat(rnd64(), rnd64(), b == blocks - 1);
  endtask

  initial begin
    int n;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_we = 0;
    cfg_index = acbc_pkg::CFG_KEY0;
    cfg_wdata = 0;
    send_idle = 0;
    recv_stall = 0;
    quiet_cycles = 0;
    beats_sent = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: zero key, extremes, short message, random pads
    send_beat('0, '0, 0);
    send_beat('1, '1, 0);
    send_beat('0, '1, 1);
    send_beat('1, '0, 1);
    send_beat(rnd64(), rnd64(), 0);
    send_beat(rnd64(), rnd64(), 1);
    load_key('1, '1, '1, '1);
    send_beat('1, '1, 0);
    send_beat('0, '0, 0);
    send_beat(rnd64(), rnd64(), 1);
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_message(4);
    send_beat(rnd64(), rnd64(), 1);
    send_message(2);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 84; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 84; end
        default: begin send_idle = 19; recv_stall = 19; end
      endcase
      if (phase == 4) load_key(0, 0, 0, 0);
      else if (phase == 2 || phase == 6) load_key(rnd64(), rnd64(), rnd64(), rnd64());
      n = 0;
      while (n < 185) begin
        int len;
        len = ($urandom_range(9) == 0) ? 1 : $urandom_range(8, 2);
        send_message(len);
        n += len;
        if ($urandom_range(15) == 0) drain();
      end
    end
    drain();
    $display("sent %0d blocks, checked %0d plaintext beats", beats_sent, plain_seen);
    $display("status ok %0d short %0d bad pad %0d pad mismatch %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
